// ----- rtl/rsc_pkg.sv -----
package rsc_pkg;

  // Bucket depths set by the wall clock.
  localparam int MINUTES = 60;
  localparam int HOURS   = 24;
  localparam int DAYS    = 7;

  // Defaults for the top-level parameters.
  localparam int ZONE_SLOTS_DEF   = 16;
  localparam int INTENT_SLOTS_DEF = 10;
  localparam int COUNT_WIDTH_DEF  = 32;

  // The latency sum saturates at this width.
  localparam int SUM_WIDTH = 48;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_ALERT   = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic        blocked;
    logic [4:0]  zone;
    logic [3:0]  intent;
    logic [31:0] latency;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic        resolved;
  } in_item_t;

  typedef struct packed {
    logic [31:0]          total_count;
    logic [31:0]          blocked_count;
    logic [31:0]          minute_total;
    logic [31:0]          minute_blocked;
    logic [31:0]          hour_total;
    logic [31:0]          day_total;
    logic [31:0]          zone_total;
    logic [31:0]          intent_total;
    logic [31:0]          latency_low;
    logic [31:0]          latency_high;
    logic [SUM_WIDTH-1:0] latency_total;
    logic [31:0]          alert_total;
  } out_item_t;

  // Minute bucket values after the current request's update.
  typedef struct packed {
    logic [31:0] total;
    logic [31:0] blocked;
  } minute_snap_t;

  // A count reported in a 32-bit field sticks at the largest 32-bit value.
  function automatic logic [31:0] clamp32(input logic [63:0] v);
    return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// ----- rtl/rsc_ram.sv -----
module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 60,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rsc_minute_bank.sv -----
module rsc_minute_bank #(
  parameter int COUNT_WIDTH = rsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [5:0]            rd_minute,
  input  logic                  upd_en,
  input  rsc_pkg::in_item_t     item,
  output rsc_pkg::minute_snap_t snap
);

  import rsc_pkg::*;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t bump(input cnt_t v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  logic [MINUTES-1:0] vld_r, vld_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               fwd_r;
  cnt_t               fwd_all_r, fwd_blk_r;
  cnt_t               q_all, q_blk;
  cnt_t               cur_all, cur_blk, new_all, new_blk;
  logic               wr_ok, rd_ok, is_req, is_clr;

  assign wr_ok  = item.minute < 6'(MINUTES);
  assign rd_ok  = rd_minute < 6'(MINUTES);
  assign is_req = upd_en && (item.command == CMD_REQUEST) && wr_ok;
  assign is_clr = upd_en && (item.command == CMD_CLEAR);

  // Bucket storage: totals and blocked counts, one entry per minute.
  rsc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MINUTES)) u_all_ram (
    .clk   (clk),
    .we    (is_req),
    .waddr (item.minute),
    .wdata (new_all),
    .re    (rd_en && rd_ok),
    .raddr (rd_minute),
    .rdata (q_all)
  );

  rsc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MINUTES)) u_blk_ram (
    .clk   (clk),
    .we    (is_req),
    .waddr (item.minute),
    .wdata (new_blk),
    .re    (rd_en && rd_ok),
    .raddr (rd_minute),
    .rdata (q_blk)
  );

  // Current bucket value: zero if never written since reset or clear, the
  // value written in the read cycle if it hit the same minute, else the RAM.
  assign cur_all = !rd_vld_r ? '0 : (fwd_r ? fwd_all_r : q_all);
  assign cur_blk = !rd_vld_r ? '0 : (fwd_r ? fwd_blk_r : q_blk);
  assign new_all = bump(cur_all);
  assign new_blk = item.blocked ? bump(cur_blk) : cur_blk;

  // Valid bits clear at once on the clear command.
  always_comb begin
    vld_nxt = vld_r;
    if (is_clr) begin
      vld_nxt = '0;
    end else if (is_req) begin
      vld_nxt[item.minute] = 1'b1;
    end
  end

  assign rd_vld_nxt = rd_ok && vld_nxt[rd_minute];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (rd_en) begin
        rd_vld_r <= rd_vld_nxt;
        fwd_r    <= is_req && (rd_minute == item.minute);
      end
    end
  end

  // Forwarded data for a read that meets a write to the same minute.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_all_r <= new_all;
      fwd_blk_r <= new_blk;
    end
  end

  // Snapshot after the update; an out-of-range minute reads zero.
  always_comb begin
    snap = '0;
    if (wr_ok && !is_clr) begin
      snap.total   = clamp32(64'(is_req ? new_all : cur_all));
      snap.blocked = clamp32(64'(is_req ? new_blk : cur_blk));
    end
  end

endmodule

// ----- rtl/rsc_counters.sv -----
module rsc_counters #(
  parameter int ZONE_SLOTS   = rsc_pkg::ZONE_SLOTS_DEF,
  parameter int INTENT_SLOTS = rsc_pkg::INTENT_SLOTS_DEF,
  parameter int COUNT_WIDTH  = rsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd_en,
  input  rsc_pkg::in_item_t  item,
  output rsc_pkg::out_item_t snap
);

  import rsc_pkg::*;

  localparam int ZIW = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
  localparam int IIW = (INTENT_SLOTS > 1) ? $clog2(INTENT_SLOTS) : 1;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t bump(input cnt_t v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  cnt_t all_r, all_nxt;
  cnt_t blocked_r, blocked_nxt;
  cnt_t fired_r, fired_nxt;
  cnt_t resolved_r, resolved_nxt;
  cnt_t hour_r   [HOURS];
  cnt_t day_r    [DAYS];
  cnt_t zone_r   [ZONE_SLOTS];
  cnt_t intent_r [INTENT_SLOTS];

  logic                 seen_r, seen_nxt;
  logic [31:0]          lat_min_r, lat_min_nxt;
  logic [31:0]          lat_max_r, lat_max_nxt;
  logic [SUM_WIDTH-1:0] lat_sum_r, lat_sum_nxt;
  logic [SUM_WIDTH:0]   sum_ext;

  logic           is_req, is_alert, is_clr;
  logic           hour_ok, day_ok, zone_ok, intent_ok;
  logic [ZIW-1:0] zone_idx;
  logic [IIW-1:0] intent_idx;
  cnt_t           hour_cur, day_cur, zone_cur, intent_cur, alert_cur;
  cnt_t           hour_inc, day_inc, zone_inc, intent_inc, alert_inc;
  cnt_t           hour_snap, day_snap, zone_snap, intent_snap, alert_snap;

  // Command decode, only while a request leaves the input register.
  assign is_req   = upd_en && (item.command == CMD_REQUEST);
  assign is_alert = upd_en && (item.command == CMD_ALERT);
  assign is_clr   = upd_en && (item.command == CMD_CLEAR);

  assign hour_ok    = item.hour < 5'(HOURS);
  assign day_ok     = item.weekday < 3'(DAYS);
  assign zone_ok    = {1'b0, item.zone} < 6'(ZONE_SLOTS);
  assign intent_ok  = {1'b0, item.intent} < 5'(INTENT_SLOTS);
  assign zone_idx   = item.zone[ZIW-1:0];
  assign intent_idx = item.intent[IIW-1:0];

  // Select the addressed entries and their incremented values.
  assign hour_cur   = hour_ok ? hour_r[item.hour] : '0;
  assign day_cur    = day_ok ? day_r[item.weekday] : '0;
  assign zone_cur   = zone_ok ? zone_r[zone_idx] : '0;
  assign intent_cur = intent_ok ? intent_r[intent_idx] : '0;
  assign alert_cur  = item.resolved ? resolved_r : fired_r;

  assign hour_inc   = bump(hour_cur);
  assign day_inc    = bump(day_cur);
  assign zone_inc   = bump(zone_cur);
  assign intent_inc = bump(intent_cur);
  assign alert_inc  = bump(alert_cur);

  // Values of the addressed entries after this request's update.
  assign hour_snap   = (is_clr || !hour_ok) ? '0 : (is_req ? hour_inc : hour_cur);
  assign day_snap    = (is_clr || !day_ok) ? '0 : (is_req ? day_inc : day_cur);
  assign zone_snap   = (is_clr || !zone_ok) ? '0 : (is_req ? zone_inc : zone_cur);
  assign intent_snap = (is_clr || !intent_ok) ? '0 : (is_req ? intent_inc : intent_cur);
  assign alert_snap  = is_clr ? '0 : (is_alert ? alert_inc : alert_cur);

  // Scalar counters.
  assign all_nxt      = is_clr ? '0 : (is_req ? bump(all_r) : all_r);
  assign blocked_nxt  = is_clr ? '0 : ((is_req && item.blocked) ? bump(blocked_r) : blocked_r);
  assign fired_nxt    = is_clr ? '0 : ((is_alert && !item.resolved) ? alert_inc : fired_r);
  assign resolved_nxt = is_clr ? '0 : ((is_alert && item.resolved) ? alert_inc : resolved_r);

  // Latency statistics; the first request after reset or clear sets the minimum.
  assign sum_ext = {1'b0, lat_sum_r} + (SUM_WIDTH + 1)'(item.latency);

  always_comb begin
    seen_nxt    = seen_r;
    lat_min_nxt = lat_min_r;
    lat_max_nxt = lat_max_r;
    lat_sum_nxt = lat_sum_r;
    if (is_clr) begin
      seen_nxt    = 1'b0;
      lat_min_nxt = '0;
      lat_max_nxt = '0;
      lat_sum_nxt = '0;
    end else if (is_req) begin
      seen_nxt = 1'b1;
      if (!seen_r || (item.latency < lat_min_r)) begin
        lat_min_nxt = item.latency;
      end
      if (item.latency > lat_max_r) begin
        lat_max_nxt = item.latency;
      end
      lat_sum_nxt = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
    end
  end

  // Counter registers; clear returns everything to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_r      <= '0;
      blocked_r  <= '0;
      fired_r    <= '0;
      resolved_r <= '0;
      seen_r     <= 1'b0;
      lat_min_r  <= '0;
      lat_max_r  <= '0;
      lat_sum_r  <= '0;
      for (int i = 0; i < HOURS; i++) hour_r[i] <= '0;
      for (int i = 0; i < DAYS; i++) day_r[i] <= '0;
      for (int i = 0; i < ZONE_SLOTS; i++) zone_r[i] <= '0;
      for (int i = 0; i < INTENT_SLOTS; i++) intent_r[i] <= '0;
    end else begin
      all_r      <= all_nxt;
      blocked_r  <= blocked_nxt;
      fired_r    <= fired_nxt;
      resolved_r <= resolved_nxt;
      seen_r     <= seen_nxt;
      lat_min_r  <= lat_min_nxt;
      lat_max_r  <= lat_max_nxt;
      lat_sum_r  <= lat_sum_nxt;
      if (is_clr) begin
        for (int i = 0; i < HOURS; i++) hour_r[i] <= '0;
        for (int i = 0; i < DAYS; i++) day_r[i] <= '0;
        for (int i = 0; i < ZONE_SLOTS; i++) zone_r[i] <= '0;
        for (int i = 0; i < INTENT_SLOTS; i++) intent_r[i] <= '0;
      end else if (is_req) begin
        if (hour_ok) begin
          hour_r[item.hour] <= hour_inc;
        end
        if (day_ok) begin
          day_r[item.weekday] <= day_inc;
        end
        if (zone_ok) begin
          zone_r[zone_idx] <= zone_inc;
        end
        if (intent_ok) begin
          intent_r[intent_idx] <= intent_inc;
        end
      end
    end
  end

  // Snapshot; minute fields come from the minute bank.
  always_comb begin
    snap               = '0;
    snap.total_count   = clamp32(64'(all_nxt));
    snap.blocked_count = clamp32(64'(blocked_nxt));
    snap.hour_total    = clamp32(64'(hour_snap));
    snap.day_total     = clamp32(64'(day_snap));
    snap.zone_total    = clamp32(64'(zone_snap));
    snap.intent_total  = clamp32(64'(intent_snap));
    snap.latency_low   = lat_min_nxt;
    snap.latency_high  = lat_max_nxt;
    snap.latency_total = lat_sum_nxt;
    snap.alert_total   = clamp32(64'(alert_snap));
  end

endmodule

// ----- rtl/request_statistics_counters.sv -----
// Request statistics counters.
//
// The in_ channel takes one event per request: record a request, record an
// alert, clear all statistics, or query. The out_ channel returns one
// snapshot per event, taken after that event's update, in order.
// An accepted request waits in the input register while the
// minute bucket RAMs are read, and loads the result register once that
// register is empty or being emptied; out_valid then shows the result.
// Throughput is one request per cycle while out_ready holds; the counters
// are updated from the input register in a single pass, and a RAM read
// that meets a write to the same minute takes the written value via a bypass.
// Reset and the clear command both zero every statistic at once: minute
// buckets carry a valid bit per entry, so there is no clearing pass.
// When the receiver stalls, the result register holds and the input
// register still fills, so in_ready drops only while both are occupied.

module request_statistics_counters #(
  parameter int ZONE_SLOTS   = rsc_pkg::ZONE_SLOTS_DEF,
  parameter int INTENT_SLOTS = rsc_pkg::INTENT_SLOTS_DEF,
  parameter int COUNT_WIDTH  = rsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsc_pkg::out_item_t out_data
);

  import rsc_pkg::*;

  logic         s1_valid_r;
  in_item_t     s1_item_r;
  logic         out_valid_r;
  out_item_t    out_r, out_nxt;
  logic         s1_adv, in_acc;
  out_item_t    cnt_snap;
  minute_snap_t min_snap;

  // Handshake: the input register moves on whenever the result register
  // is empty or being emptied.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
  end

  rsc_minute_bank #(.COUNT_WIDTH(COUNT_WIDTH)) u_minute_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_minute (in_data.minute),
    .upd_en    (s1_adv),
    .item      (s1_item_r),
    .snap      (min_snap)
  );

  rsc_counters #(
    .ZONE_SLOTS   (ZONE_SLOTS),
    .INTENT_SLOTS (INTENT_SLOTS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_counters (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_adv),
    .item   (s1_item_r),
    .snap   (cnt_snap)
  );

  // Merge the minute fields into the counter snapshot.
  always_comb begin
    out_nxt                = cnt_snap;
    out_nxt.minute_total   = min_snap.total;
    out_nxt.minute_blocked = min_snap.blocked;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/rsc_checker.sv -----
module rsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rsc_pkg::out_item_t out_data
);

  import rsc_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // With the output free, the block always takes a new request.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // An accepted request reaches the output once the output is free in the
  // cycle after acceptance.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("result late");

  // The latency minimum never exceeds the maximum, and blocked never
  // exceeds the total.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.latency_low <= out_data.latency_high) &&
                  (out_data.blocked_count <= out_data.total_count))
    else $error("statistics out of order");

endmodule

bind request_statistics_counters rsc_checker u_rsc_checker (.*);
